/* design/uer_pkg.sv */
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// Field widths, configuration register indexes and reset values, the phase
// encoding and the reciprocal constants of the ticks-to-centimeter divide.
// ----------------------------------------------------------------------------
package uer_pkg;

   localparam int COUNT_WIDTH  = 16;
   localparam int TICKS_PER_CM = 58;

   localparam int PHASE_CNT_W = 16;
   localparam int TRIG_W      = 8;
   localparam int WIN_W       = 16;
   localparam int NEAR_W      = 8;
   localparam int DIST_W      = 8;
   localparam int DIST_MAX    = (1 << DIST_W) - 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_CM       = 2'd2;

   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd10;
   localparam logic [WIN_W-1:0]  WINDOW_TICKS_RST  = 16'd30000;
   localparam logic [NEAR_W-1:0] NEAR_CM_RST       = 8'd30;

   // distance = width / TICKS_PER_CM through a rounded-up reciprocal
   localparam int DIV_SHIFT = 24;
   localparam int DIV_MULT  = ((1 << DIV_SHIFT) + TICKS_PER_CM - 1) / TICKS_PER_CM;
   localparam int SAT_LIMIT = (DIST_MAX + 1) * TICKS_PER_CM;
   localparam int SAT_W     = $clog2(SAT_LIMIT);
   localparam int MULT_W    = $clog2(DIV_MULT + 1);
   localparam int PROD_W    = SAT_W + MULT_W;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_TRIG   = 3'b010,
      PH_LISTEN = 3'b100
   } phase_type;

   typedef struct packed {
      logic [TRIG_W-1:0] trigger_ticks;
      logic [WIN_W-1:0]  window_ticks;
      logic [NEAR_W-1:0] near_cm;
   } cfg_type;

   typedef struct packed {
      logic start_req;
      logic echo;
   } req_type;

   typedef struct packed {
      logic              trigger;
      logic              busy_res;
      logic              done_res;
      logic [DIST_W-1:0] distance_cm;
      logic              near;
   } rsp_type;

endpackage

/* design/uer_if.sv */
// ----------------------------------------------------------------------------
// uer_if: channel interfaces of the ultrasonic echo ranger
// Tick request channel, result channel and register write channel, each a
// valid/ready handshake with a source and a sink side.
// ----------------------------------------------------------------------------
interface uer_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo;

   modport source (output valid, output start_req, output echo, input ready);
   modport sink (input valid, input start_req, input echo, output ready);
endinterface

interface uer_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      trigger;
   logic                      busy_res;
   logic                      done_res;
   logic [uer_pkg::DIST_W-1:0] distance_cm;
   logic                      near;

   modport source (output valid, output trigger, output busy_res, output done_res,
                   output distance_cm, output near, input ready);
   modport sink (input valid, input trigger, input busy_res, input done_res,
                 input distance_cm, input near, output ready);
endinterface

interface uer_csr_if;
   logic                          valid;
   logic                          ready;
   logic [uer_pkg::CSR_IDX_W-1:0]  index;
   logic [uer_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* design/uer_csr.sv */
// ----------------------------------------------------------------------------
// uer_csr: configuration registers
// Holds trigger length, window length and near threshold; one write
// transaction per cycle, unknown indexes are dropped.
// ----------------------------------------------------------------------------
module uer_csr (
   input  logic             clock,
   input  logic             reset,
   uer_csr_if.sink          csr_chan,
   output uer_pkg::cfg_type cfg
);

   uer_pkg::cfg_type cfg_ff;
   uer_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            uer_pkg::CSR_TRIGGER_TICKS: cfg_in.trigger_ticks =
               csr_chan.data[uer_pkg::TRIG_W-1:0];
            uer_pkg::CSR_WINDOW_TICKS: cfg_in.window_ticks =
               csr_chan.data[uer_pkg::WIN_W-1:0];
            uer_pkg::CSR_NEAR_CM: cfg_in.near_cm = csr_chan.data[uer_pkg::NEAR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
         cfg_ff.window_ticks  <= uer_pkg::WINDOW_TICKS_RST;
         cfg_ff.near_cm       <= uer_pkg::NEAR_CM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/uer_dist.sv */
// ----------------------------------------------------------------------------
// uer_dist: echo width to distance conversion
// Divides the echo width by the ticks per centimeter with a reciprocal
// multiply and saturates the distance to its field range.
// ----------------------------------------------------------------------------
module uer_dist (
   input  logic [uer_pkg::COUNT_WIDTH-1:0] width_cnt,
   output logic [uer_pkg::DIST_W-1:0]      distance
);

   localparam int ProdW = uer_pkg::PROD_W;
   localparam int SatW  = uer_pkg::SAT_W;

   logic [31:0]      width_ext;
   logic             sat;
   logic [ProdW-1:0] prod;

   assign width_ext = 32'(width_cnt);
   assign sat       = width_ext >= 32'(uer_pkg::SAT_LIMIT);
   assign prod      = ProdW'(width_ext[SatW-1:0]) * ProdW'(uer_pkg::DIV_MULT);
   assign distance  = sat ? uer_pkg::DIST_W'(uer_pkg::DIST_MAX)
                          : prod[uer_pkg::DIV_SHIFT +: uer_pkg::DIST_W];

endmodule

/* design/uer_core.sv */
// ----------------------------------------------------------------------------
// uer_core: measurement sequencer
// Trigger and listen phases, echo edge detection and width capture, and the
// distance and near flag at window close; state moves once per tick.
// ----------------------------------------------------------------------------
module uer_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  uer_pkg::req_type item,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::rsp_type result
);

   localparam int CountW    = uer_pkg::COUNT_WIDTH;
   localparam int PhaseCntW = uer_pkg::PHASE_CNT_W;
   localparam int DistW     = uer_pkg::DIST_W;

   uer_pkg::phase_type   phase_ff, phase_in;
   logic [PhaseCntW-1:0] phase_count_ff, phase_count_in;
   logic [CountW-1:0]    echo_width_ff, echo_width_in;
   logic                 echo_prev_ff, echo_prev_in;
   logic                 in_echo_ff, in_echo_in;
   logic [CountW-1:0]    captured_width_ff, captured_width_in;
   logic                 captured_valid_ff, captured_valid_in;
   logic [DistW-1:0]     distance_ff, distance_in;
   logic                 near_ff, near_in;

   logic                 rise;
   logic                 fall;
   logic                 done;
   logic [PhaseCntW-1:0] count_inc;
   logic [DistW-1:0]     dist_q;

   assign rise         = item.echo && !echo_prev_ff;
   assign fall         = !item.echo && echo_prev_ff;
   assign count_inc    = phase_count_ff + PhaseCntW'(1);
   assign echo_prev_in = item.echo;

   // echo pulse tracking inside the window, cleared on a start request while idle
   always_comb begin
      echo_width_in     = echo_width_ff;
      in_echo_in        = in_echo_ff;
      captured_width_in = captured_width_ff;
      captured_valid_in = captured_valid_ff;
      if (phase_ff == uer_pkg::PH_LISTEN) begin
         if (rise) begin
            echo_width_in = CountW'(1);
            in_echo_in    = 1'b1;
         end else if (fall) begin
            if (in_echo_ff) begin
               captured_width_in = echo_width_ff;
               captured_valid_in = 1'b1;
            end
            in_echo_in = 1'b0;
         end else if (in_echo_ff && item.echo && (echo_width_ff != '1)) begin
            echo_width_in = echo_width_ff + CountW'(1);
         end
      end else if (phase_ff != uer_pkg::PH_TRIG && item.start_req) begin
         echo_width_in     = '0;
         in_echo_in        = 1'b0;
         captured_valid_in = 1'b0;
      end
   end

   uer_dist u_dist (
      .width_cnt (captured_width_in),
      .distance  (dist_q)
   );

   // phase sequencing and window close
   always_comb begin
      phase_in       = phase_ff;
      phase_count_in = phase_count_ff;
      distance_in    = distance_ff;
      near_in        = near_ff;
      done           = 1'b0;
      case (phase_ff)
         uer_pkg::PH_TRIG: begin
            phase_count_in = count_inc;
            if (count_inc >= PhaseCntW'(cfg.trigger_ticks)) begin
               phase_in       = uer_pkg::PH_LISTEN;
               phase_count_in = '0;
            end
         end
         uer_pkg::PH_LISTEN: begin
            phase_count_in = count_inc;
            if (count_inc >= PhaseCntW'(cfg.window_ticks)) begin
               done           = 1'b1;
               phase_in       = uer_pkg::PH_IDLE;
               phase_count_in = '0;
               distance_in    = captured_valid_in ? dist_q : '0;
               near_in        = (distance_in != '0) && (distance_in < cfg.near_cm);
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
            if (item.start_req) begin
               phase_in       = uer_pkg::PH_TRIG;
               phase_count_in = '0;
            end
         end
      endcase
   end

   assign result.trigger     = (phase_in == uer_pkg::PH_TRIG);
   assign result.busy_res    = (phase_in == uer_pkg::PH_TRIG) ||
                               (phase_in == uer_pkg::PH_LISTEN);
   assign result.done_res    = done;
   assign result.distance_cm = distance_in;
   assign result.near        = near_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= uer_pkg::PH_IDLE;
         phase_count_ff    <= '0;
         echo_width_ff     <= '0;
         echo_prev_ff      <= 1'b0;
         in_echo_ff        <= 1'b0;
         captured_width_ff <= '0;
         captured_valid_ff <= 1'b0;
         distance_ff       <= '0;
         near_ff           <= 1'b0;
      end else if (adv) begin
         phase_ff          <= phase_in;
         phase_count_ff    <= phase_count_in;
         echo_width_ff     <= echo_width_in;
         echo_prev_ff      <= echo_prev_in;
         in_echo_ff        <= in_echo_in;
         captured_width_ff <= captured_width_in;
         captured_valid_ff <= captured_valid_in;
         distance_ff       <= distance_in;
         near_ff           <= near_in;
      end
   end

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      adv && done |=> phase_ff == uer_pkg::PH_IDLE)
      else $error("phase not idle after window close");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      adv && phase_ff == uer_pkg::PH_IDLE && item.start_req
      |=> phase_ff == uer_pkg::PH_TRIG && !captured_valid_ff && !in_echo_ff)
      else $error("start did not enter trigger phase with capture cleared");

   a_trig_no_capture: assert property (@(posedge clock) disable iff (reset)
      phase_ff == uer_pkg::PH_TRIG |-> !captured_valid_ff && !in_echo_ff)
      else $error("capture state set during trigger phase");

   a_near_nonzero: assert property (@(posedge clock) disable iff (reset)
      near_ff |-> distance_ff != '0)
      else $error("near flag with zero distance");

endmodule

/* design/ultrasonic_echo_ranger.sv */
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: range controller for a trigger/echo ultrasonic sensor
// Feed one request transaction per microsecond tick on req_chan, carrying a
// start request and the sampled echo pin. Every request gives exactly one
// result transaction on rsp_chan: trigger pin level, busy, done, the last
// distance in cm (0 for no echo) and the near flag.
// Registers on csr_chan: 0 trigger length, 1 window length, 2 near
// threshold; write them only while no measurement is running.
// A request passes through one input register, then the sequencer logic with
// its divide-by-constant multiplier, then the result register. Throughput is
// one transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input
// register takes one more request; the sequencer state only moves when a
// request passes into the result register, so nothing is lost or repeated.
// Reset returns the block to idle with cleared distance and default
// register values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
   input  logic     clock,
   input  logic     reset,
   uer_req_if.sink  req_chan,
   uer_rsp_if.source rsp_chan,
   uer_csr_if.sink  csr_chan
);

   uer_pkg::cfg_type cfg;
   uer_pkg::rsp_type result;

   logic             req_valid_ff, req_valid_in;
   uer_pkg::req_type req_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   uer_pkg::rsp_type rsp_data_ff;
   logic             adv;
   logic             req_take;

   assign adv            = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || adv;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_valid_in   = req_take || (req_valid_ff && !adv);
   assign rsp_valid_in   = adv || (rsp_valid_ff && !rsp_chan.ready);

   uer_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   uer_core u_core (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .item   (req_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.start_req <= req_chan.start_req;
         req_item_ff.echo      <= req_chan.echo;
      end
      if (adv) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.trigger     = rsp_data_ff.trigger;
   assign rsp_chan.busy_res    = rsp_data_ff.busy_res;
   assign rsp_chan.done_res    = rsp_data_ff.done_res;
   assign rsp_chan.distance_cm = rsp_data_ff.distance_cm;
   assign rsp_chan.near        = rsp_data_ff.near;

endmodule
